@@ rtl/core/sbh_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sbh_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      SBH_IDLE,
      SBH_PAD_MARK,
      SBH_PAD_ZERO,
      SBH_PAD_LEN,
      SBH_LOAD,
      SBH_ROUND,
      SBH_UPDATE,
      SBH_OUT
   } sbh_state_type;

   // Request action codes
   typedef enum logic [1:0] {
      SBH_ACT_ABSORB      = 2'd0,
      SBH_ACT_ABSORB_LAST = 2'd1,
      SBH_ACT_FINISH      = 2'd2,
      SBH_ACT_NONE        = 2'd3
   } sbh_action_type;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned LEN_W    = 64;
   localparam int unsigned DIGEST_N = 8;

   localparam logic [BYTE_W-1:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0]        LEN_START     = 6'd56;
   localparam logic [5:0]        LAST_SLOT     = 6'd63;
   localparam logic [5:0]        LAST_ROUND    = 6'd63;
   localparam logic [2:0]        LAST_INDEX    = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   // Round function sigma on the a word
   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   // Round function sigma on the e word
   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   // Schedule sigma on w[t-15]
   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   // Schedule sigma on w[t-2]
   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/sbh_stream_if.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher stream channels
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_byte;
   logic [1:0] action;

   modport source (output valid, output message_byte, output action, input ready);
   modport sink   (input valid, input message_byte, input action, output ready);
endinterface

interface sbh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sha256_byte_stream_hasher_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one message byte and an action per transfer: absorb,
//   absorb then finish, or finish without a byte (empty message tail).
//   Action code 3 is accepted and dropped. rsp_if returns the eight digest
//   words, word_index 0 first, last_word set on index 7.
//   A byte that does not complete a block leaves the core idle and ready. The
//   64th byte of a block starts a compression (load, 64 rounds through one
//   shared round unit, chaining update); req_if.ready stays low meanwhile.
//   Finish runs the padding one byte per cycle up to the 64th slot, with a
//   pause in the zero state where the length field starts, then one or two
//   compressions, then the eight words appear on rsp_if one per cycle while
//   the receiver takes them.
//   A stalled receiver holds the current word; no new request is taken
//   until the eighth word is transferred.
//   Reset (synchronous) loads the initial hash value and clears the byte
//   and bit counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sbh_req_if.sink    req_if,
   sbh_rsp_if.source  rsp_if
);

   sbh_pkg::sbh_state_type state_ff, state_in;
   sbh_pkg::sbh_state_type ret_ff, ret_in;
   sbh_pkg::sbh_action_type req_action;

   logic [511:0] blk_ff, blk_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [63:0]  len_ff, len_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [2:0]   idx_ff, idx_in;
   logic [31:0]  cv_ff [8];
   logic [31:0]  cv_in [8];
   logic [31:0]  wv_ff [8];
   logic [31:0]  wv_in [8];

   logic        req_xfer;
   logic        rsp_xfer;
   logic        shift_en;
   logic [7:0]  shift_byte;
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2;

   assign req_action = sbh_pkg::sbh_action_type'(req_if.action);
   assign req_xfer   = req_if.valid && req_if.ready;
   assign rsp_xfer   = rsp_if.valid && rsp_if.ready;

   // Drive channel handshakes and response payload
   assign req_if.ready       = (state_ff == sbh_pkg::SBH_IDLE);
   assign rsp_if.valid       = (state_ff == sbh_pkg::SBH_OUT);
   assign rsp_if.digest_word = cv_ff[idx_ff];
   assign rsp_if.word_index  = idx_ff;
   assign rsp_if.last_word   = (idx_ff == sbh_pkg::LAST_INDEX);

   // Tap the schedule window
   assign w0  = blk_ff[511:480];
   assign w1  = blk_ff[479:448];
   assign w9  = blk_ff[223:192];
   assign w14 = blk_ff[63:32];
   assign w_new = sbh_pkg::small_sigma1(w14) + w9 + sbh_pkg::small_sigma0(w1) + w0;

   // Evaluate one compression round
   assign t1 = wv_ff[7] + sbh_pkg::big_sigma1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + sbh_pkg::ROUND_K[rnd_ff] + w0;
   assign t2 = sbh_pkg::big_sigma0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   // Select next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         sbh_pkg::SBH_IDLE: begin
            if (req_xfer) begin
               unique case (req_action)
                  sbh_pkg::SBH_ACT_ABSORB: begin
                     if (cnt_ff == sbh_pkg::LAST_SLOT) begin
                        state_in = sbh_pkg::SBH_LOAD;
                        ret_in   = sbh_pkg::SBH_IDLE;
                     end
                  end
                  sbh_pkg::SBH_ACT_ABSORB_LAST: begin
                     if (cnt_ff == sbh_pkg::LAST_SLOT) begin
                        state_in = sbh_pkg::SBH_LOAD;
                        ret_in   = sbh_pkg::SBH_PAD_MARK;
                     end else begin
                        state_in = sbh_pkg::SBH_PAD_MARK;
                     end
                  end
                  sbh_pkg::SBH_ACT_FINISH: begin
                     state_in = sbh_pkg::SBH_PAD_MARK;
                  end
                  default: begin
                     state_in = sbh_pkg::SBH_IDLE;
                  end
               endcase
            end
         end
         sbh_pkg::SBH_PAD_MARK: begin
            if (cnt_ff == sbh_pkg::LAST_SLOT) begin
               state_in = sbh_pkg::SBH_LOAD;
               ret_in   = sbh_pkg::SBH_PAD_ZERO;
            end else begin
               state_in = sbh_pkg::SBH_PAD_ZERO;
            end
         end
         sbh_pkg::SBH_PAD_ZERO: begin
            if (cnt_ff == sbh_pkg::LEN_START) begin
               state_in = sbh_pkg::SBH_PAD_LEN;
            end else if (cnt_ff == sbh_pkg::LAST_SLOT) begin
               state_in = sbh_pkg::SBH_LOAD;
               ret_in   = sbh_pkg::SBH_PAD_ZERO;
            end
         end
         sbh_pkg::SBH_PAD_LEN: begin
            if (cnt_ff == sbh_pkg::LAST_SLOT) begin
               state_in = sbh_pkg::SBH_LOAD;
               ret_in   = sbh_pkg::SBH_OUT;
            end
         end
         sbh_pkg::SBH_LOAD: begin
            state_in = sbh_pkg::SBH_ROUND;
         end
         sbh_pkg::SBH_ROUND: begin
            if (rnd_ff == sbh_pkg::LAST_ROUND) begin
               state_in = sbh_pkg::SBH_UPDATE;
            end
         end
         sbh_pkg::SBH_UPDATE: begin
            state_in = ret_ff;
         end
         sbh_pkg::SBH_OUT: begin
            if (rsp_xfer && (idx_ff == sbh_pkg::LAST_INDEX)) begin
               state_in = sbh_pkg::SBH_IDLE;
            end
         end
         default: begin
            state_in = sbh_pkg::SBH_IDLE;
         end
      endcase
   end

   // Pick the byte to shift into the block window
   always_comb begin
      shift_en   = 1'b0;
      shift_byte = req_if.message_byte;
      unique case (state_ff)
         sbh_pkg::SBH_IDLE: begin
            shift_en = req_xfer && ((req_action == sbh_pkg::SBH_ACT_ABSORB) ||
                                    (req_action == sbh_pkg::SBH_ACT_ABSORB_LAST));
         end
         sbh_pkg::SBH_PAD_MARK: begin
            shift_en   = 1'b1;
            shift_byte = sbh_pkg::PAD_MARK_BYTE;
         end
         sbh_pkg::SBH_PAD_ZERO: begin
            shift_en   = (cnt_ff != sbh_pkg::LEN_START);
            shift_byte = 8'h00;
         end
         sbh_pkg::SBH_PAD_LEN: begin
            shift_en   = 1'b1;
            shift_byte = len_ff[63:56];
         end
         default: begin
            shift_en = 1'b0;
         end
      endcase
   end

   // Update datapath registers
   always_comb begin
      blk_in = blk_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      rnd_in = rnd_ff;
      idx_in = idx_ff;
      cv_in  = cv_ff;
      wv_in  = wv_ff;

      // Shift a byte and advance the fill count
      if (shift_en) begin
         blk_in = {blk_ff[503:0], shift_byte};
         cnt_in = cnt_ff + 6'd1;
      end

      // Count message bits; shift out length bytes during padding
      if (state_ff == sbh_pkg::SBH_IDLE && shift_en) begin
         len_in = len_ff + 64'd8;
      end else if (state_ff == sbh_pkg::SBH_PAD_LEN) begin
         len_in = {len_ff[55:0], 8'h00};
      end

      unique case (state_ff)
         sbh_pkg::SBH_LOAD: begin
            wv_in  = cv_ff;
            rnd_in = 6'd0;
         end
         sbh_pkg::SBH_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            blk_in   = {blk_ff[479:0], w_new};
            rnd_in   = rnd_ff + 6'd1;
         end
         sbh_pkg::SBH_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] + wv_ff[i];
            end
            idx_in = 3'd0;
         end
         sbh_pkg::SBH_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == sbh_pkg::LAST_INDEX) begin
                  cv_in  = sbh_pkg::INIT_HASH;
                  len_in = 64'd0;
                  cnt_in = 6'd0;
               end
            end
         end
         default: begin
            rnd_in = rnd_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbh_pkg::SBH_IDLE;
         ret_ff   <= sbh_pkg::SBH_IDLE;
         cnt_ff   <= 6'd0;
         len_ff   <= 64'd0;
         idx_ff   <= 3'd0;
         cv_ff    <= sbh_pkg::INIT_HASH;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         cv_ff    <= cv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
      wv_ff  <= wv_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/sbh_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the top level channels for digest sequencing and handshake rules.
// ----------------------------------------------------------------------------
`default_nettype none

module sbh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // Stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                  && $stable(rsp_word_index))
      else $error("stalled digest word changed");

   // Never take a request while a digest is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken during digest output");

   // Words come out in index order
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index skipped");

   // Last flag marks index seven only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last word flag mismatch");

   // Block returns to accepting after the final word
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid && req_ready)
      else $error("block not idle after digest");

endmodule

bind sha256_byte_stream_hasher_core sbh_checker u_sbh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_digest_word (rsp_if.digest_word),
   .rsp_word_index  (rsp_if.word_index),
   .rsp_last_word   (rsp_if.last_word)
);

`default_nettype wire

@@ sim/sha256_byte_stream_hasher_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core testbench
// Streams messages of assorted lengths (empty, short, and across the padding
// boundaries) with ignored action codes mixed in. The sender works in bursts
// with gaps and the receiver stalls on shifting patterns, with one long
// hold-off. A behavioral SHA-256 predicts every digest word, and each word
// that comes back is checked field by field against it.
// ----------------------------------------------------------------------------

module sha256_byte_stream_hasher_core_tb;

   localparam int unsigned RANDOM_ITEMS = 260;
   localparam int unsigned IDLE_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 100;

   localparam logic [31:0] K256 [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   localparam logic [31:0] H0_WORDS [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   typedef struct packed {
      logic [7:0]              message_byte;
      sbh_pkg::sbh_action_type action;
   } hash_request_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_entry_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_HALF,
      RX_SPARSE,
      RX_TOGGLE
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbh_req_if req_ch ();
   sbh_rsp_if rsp_ch ();

   sha256_byte_stream_hasher_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Free-running clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hash_request_type request_q [$];
   digest_entry_type digest_q [$];
   int unsigned      random_items = 0;
   int unsigned      fail_count   = 0;

   // Predictor state: chaining value, partial block and compressed bit count
   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] bit_total;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64-round compression over block_bytes into hash_state
   function automatic void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] s0, s1, ch, maj, t1;
      int unsigned t;
      for (t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (t = 0; t < 64; t++) begin
         s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
         ch  = (e & f) ^ (~e & g);
         t1  = h + s1 + ch + K256[t] + w[t];
         s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
         maj = (a & b) ^ (a & c) ^ (b & c);
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + s0 + maj;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endfunction

   function automatic void restart_message();
      int unsigned i;
      for (i = 0; i < 8; i++)
         hash_state[i] = H0_WORDS[i];
      block_fill = 0;
      bit_total  = '0;
   endfunction

   // Pad, append the bit length, compress and queue the eight digest words
   function automatic void finish_message();
      logic [63:0] length_bits;
      int unsigned i;
      length_bits = bit_total + 64'(block_fill) * 64'd8;
      block_bytes[block_fill] = 8'h80;
      for (i = block_fill + 1; i < 64; i++)
         block_bytes[i] = 8'h00;
      // No room left for the length field: spill into an extra block
      if (block_fill >= 56) begin
         compress_block();
         for (i = 0; i < 56; i++)
            block_bytes[i] = 8'h00;
      end
      for (i = 0; i < 8; i++)
         block_bytes[63-i] = length_bits[8*i +: 8];
      compress_block();
      for (i = 0; i < 8; i++)
         digest_q.push_back('{digest_word: hash_state[i], word_index: 3'(i),
                              last_word: (i == 7)});
      restart_message();
   endfunction

   // Advance the predictor by one accepted request
   function automatic void hash_model_accept(input logic [7:0] msg_byte,
                                             input sbh_pkg::sbh_action_type act);
      if (act == sbh_pkg::SBH_ACT_NONE)
         return;
      if (act != sbh_pkg::SBH_ACT_FINISH) begin
         block_bytes[block_fill] = msg_byte;
         block_fill++;
         if (block_fill == 64) begin
            compress_block();
            bit_total += 64'd512;
            block_fill = 0;
         end
      end
      if (act != sbh_pkg::SBH_ACT_ABSORB)
         finish_message();
   endfunction

   task automatic push_request(input logic [7:0] msg_byte,
                               input sbh_pkg::sbh_action_type act);
      request_q.push_back('{message_byte: msg_byte, action: act});
   endtask

   // Mostly uniform bytes, with the all-zero and all-one extremes favored
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Queue one message; the tail is either absorb-then-finish or a bare finish
   task automatic queue_message(input int unsigned len);
      int unsigned i;
      bit          tail_byte;
      tail_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            push_request(pick_byte(), sbh_pkg::SBH_ACT_NONE);
         if (tail_byte && i == len - 1)
            push_request(pick_byte(), sbh_pkg::SBH_ACT_ABSORB_LAST);
         else
            push_request(pick_byte(), sbh_pkg::SBH_ACT_ABSORB);
      end
      if (!tail_byte)
         push_request(pick_byte(), sbh_pkg::SBH_ACT_FINISH);
      random_items += tail_byte ? len : len + 1;
   endtask

   // Request driver: bursts of random length separated by random gaps
   int unsigned      burst_left = 1;
   int unsigned      gap_left   = 0;
   hash_request_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            hash_model_accept(req_ch.message_byte,
                              sbh_pkg::sbh_action_type'(req_ch.action));
         // Hold the current offer until it is taken
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0 || request_q.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               next_req = request_q.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.message_byte <= next_req.message_byte;
               req_ch.action       <= next_req.action;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                         : $urandom_range(0, 3);
               end
            end
         end
      end
   end

   // Digest monitor: check each transfer, stall on a changing pattern
   int unsigned      words_taken = 0;
   int unsigned      hold_left   = 0;
   bit               hold_done   = 1'b0;
   int unsigned      pattern_left = 0;
   rx_pattern_type   rx_pattern  = RX_ALWAYS;
   digest_entry_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_taken++;
            if (digest_q.size() == 0) begin
               $error("unexpected digest word %h (index %0d) with nothing pending",
                      rsp_ch.digest_word, rsp_ch.word_index);
               fail_count++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_ch.digest_word !== want.digest_word) begin
                  $error("digest_word mismatch: expected %h, got %h",
                         want.digest_word, rsp_ch.digest_word);
                  fail_count++;
               end
               if (rsp_ch.word_index !== want.word_index) begin
                  $error("word_index mismatch: expected %0d, got %0d",
                         want.word_index, rsp_ch.word_index);
                  fail_count++;
               end
               if (rsp_ch.last_word !== want.last_word) begin
                  $error("last_word mismatch: expected %0d, got %0d",
                         want.last_word, rsp_ch.last_word);
                  fail_count++;
               end
            end
         end
         // Hold off once for a long stretch so the core backs up its input
         if (!hold_done && words_taken >= 24) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(64, 256);
            end else begin
               pattern_left--;
            end
            case (rx_pattern)
               RX_ALWAYS: rsp_ch.ready <= 1'b1;
               RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               RX_TOGGLE: rsp_ch.ready <= pattern_left[0];
               default:   rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   int unsigned boundary_lens [4] = '{55, 56, 63, 64};

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.message_byte = 8'h00;
      req_ch.action       = sbh_pkg::SBH_ACT_ABSORB;
      rsp_ch.ready        = 1'b0;
      restart_message();

      // Empty message; the byte rides along and must be ignored
      push_request(8'hA5, sbh_pkg::SBH_ACT_FINISH);
      // Unused action code: dropped without touching the state
      push_request(8'hFF, sbh_pkg::SBH_ACT_NONE);
      // Single zero byte finished in the same transfer
      push_request(8'h00, sbh_pkg::SBH_ACT_ABSORB_LAST);
      // "abc"
      push_request(8'h61, sbh_pkg::SBH_ACT_ABSORB);
      push_request(8'h62, sbh_pkg::SBH_ACT_ABSORB);
      push_request(8'h63, sbh_pkg::SBH_ACT_ABSORB_LAST);
      // Dropped code in the middle of a message, then a bare finish
      push_request(8'hFF, sbh_pkg::SBH_ACT_ABSORB);
      push_request(8'h00, sbh_pkg::SBH_ACT_NONE);
      push_request(8'h00, sbh_pkg::SBH_ACT_ABSORB);
      push_request(8'hFF, sbh_pkg::SBH_ACT_FINISH);
      // Back-to-back empty messages after a finish
      push_request(8'h00, sbh_pkg::SBH_ACT_FINISH);
      push_request(8'hFF, sbh_pkg::SBH_ACT_FINISH);
      push_request(8'hFF, sbh_pkg::SBH_ACT_ABSORB_LAST);
      push_request(8'h55, sbh_pkg::SBH_ACT_NONE);
      push_request(8'hAA, sbh_pkg::SBH_ACT_ABSORB_LAST);

      // Padding boundaries: last fit, extra block, full block, then short ones
      foreach (boundary_lens[i]) begin
         queue_message($urandom_range(0, 12));
         queue_message(boundary_lens[i]);
      end
      while (random_items < RANDOM_ITEMS)
         queue_message($urandom_range(0, 12));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: all requests taken, then all digest words back
      while (request_q.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (digest_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && digest_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
